// File: rtl/dla_pkg.sv
// Shared types, constants and helpers for the lattice aggregation step block.
// Used by dla_ctrl, dla_dpath and dla_lattice_aggregation_step.
`default_nettype none

package dla_pkg;

  localparam int MAX_PARTICLES = 4096;
  localparam int LATTICE_MAX   = 1024;

  localparam int COORD_W = 10;
  localparam int EXT_W   = COORD_W + 1;
  localparam int CNT_W   = $clog2(MAX_PARTICLES + 1);
  localparam int ADDR_W  = $clog2(MAX_PARTICLES);
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 2;

  // one cluster store entry: x | y << 10 | z << 20
  localparam int ENTRY_W = 3 * COORD_W;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 80;

  // result tdata offsets
  localparam int OUT_JOINED_LSB = 0;
  localparam int OUT_CNT_LSB    = 1 + 6 * COORD_W;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [EXT_W-1:0]   ext_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // smaller of LATTICE_MAX and the coordinate range
  localparam ext_t EXT_LIMIT = (LATTICE_MAX < (1 << COORD_W)) ?
                               ext_t'(LATTICE_MAX) : ext_t'(1 << COORD_W);
  localparam cnt_t CNT_MAX   = cnt_t'(MAX_PARTICLES);

  typedef enum logic [2:0] {
    DIR_Y_INC = 3'd0,
    DIR_Y_DEC = 3'd1,
    DIR_X_DEC = 3'd2,
    DIR_X_INC = 3'd3,
    DIR_Z_DEC = 3'd4,
    DIR_Z_INC = 3'd5
  } dir_t;

  localparam logic OP_WALK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd3;

  localparam ext_t RST_EXTENT = 11'd900;
  localparam cnt_t RST_TARGET = 13'd1000;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture input item
    logic start;     // seed cluster, place walker
    logic move;      // step walker, arm scan
    logic scan;      // read cluster entries
    logic append;    // append walker to cluster
    logic load_out;  // load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_start;
    logic is_done;
    logic scan_busy;
    logic hit;
  } stat_t;

  // clamp an extent register to 1 .. EXT_LIMIT
  function automatic ext_t clamp_extent(input ext_t r);
    ext_t e;
    e = r;
    if (e > EXT_LIMIT) e = EXT_LIMIT;
    if (e == '0) e = ext_t'(1);
    return e;
  endfunction

endpackage

`default_nettype wire

// File: rtl/dla_ctrl.sv
// Sequencer for the aggregation step: accept, move, scan, join, result.
// Depends on dla_pkg.
`default_nettype none

module dla_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  input  wire dla_pkg::stat_t stat,
  output dla_pkg::cmd_t      cmd
);
  import dla_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MOVE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_JOIN   = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (stat.is_start) begin
          cmd.start  = 1'b1;
          state_next = ST_COMMIT;
        end else if (stat.is_done) begin
          state_next = ST_COMMIT;
        end else begin
          cmd.move   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (!stat.scan_busy) state_next = ST_JOIN;
      end
      ST_JOIN: begin
        cmd.append = stat.hit;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out)  m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dla_dpath.sv
// Datapath: walker and cluster state, cluster store, contact scan, result register.
// Depends on dla_pkg; driven by dla_ctrl commands.
`default_nettype none

module dla_dpath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire dla_pkg::cmd_t                cmd,
  input  wire logic                         s_tuser,
  input  wire logic [dla_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire dla_pkg::ext_t                ext_w,
  input  wire dla_pkg::ext_t                ext_h,
  input  wire dla_pkg::ext_t                ext_d,
  input  wire dla_pkg::cnt_t                target,
  output dla_pkg::stat_t                    stat,
  output logic [dla_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import dla_pkg::*;

  function automatic logic near1(input coord_t a, input coord_t b);
    logic [COORD_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    return (d == '0) || (d == (COORD_W+1)'(1)) || (d == '1);
  endfunction

  // captured item
  logic   op_q;
  logic [2:0] dir_q;
  coord_t exit_x, exit_y, exit_z, spawn_x, spawn_y, spawn_z;

  // architectural state
  coord_t wx, wy, wz;
  cnt_t   size;

  // scan
  cnt_t   idx;
  logic   rd_en, rd_valid, hit;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] mem [MAX_PARTICLES];

  // result
  logic   res_joined;
  coord_t res_x, res_y, res_z;

  // move
  ext_t nx, ny, nz;
  logic out_of_lattice;
  logic done;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  assign done = (size >= target) || (size >= CNT_MAX);

  always_comb begin
    nx = {1'b0, wx};
    ny = {1'b0, wy};
    nz = {1'b0, wz};
    case (dir_q)
      DIR_Y_INC: ny = ny + ext_t'(1);
      DIR_Y_DEC: ny = ny - ext_t'(1);
      DIR_X_DEC: nx = nx - ext_t'(1);
      DIR_X_INC: nx = nx + ext_t'(1);
      DIR_Z_DEC: nz = nz - ext_t'(1);
      DIR_Z_INC: nz = nz + ext_t'(1);
      default: ;  // no move
    endcase
    // a step below zero wraps to all ones, which is never below an extent
    out_of_lattice = (nx >= ext_w) || (ny >= ext_h) || (nz >= ext_d);
  end

  assign rd_en = cmd.scan && (idx < size);

  always_comb begin
    wr_en   = cmd.start || cmd.append;
    wr_addr = cmd.start ? '0 : size[ADDR_W-1:0];
    wr_data = cmd.start ?
              {COORD_W'(ext_d >> 1), COORD_W'(ext_h >> 1), COORD_W'(ext_w >> 1)} :
              {wz, wy, wx};
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= s_tuser;
      dir_q   <= s_tdata[2:0];
      exit_x  <= s_tdata[12:3];
      exit_y  <= s_tdata[22:13];
      exit_z  <= s_tdata[32:23];
      spawn_x <= s_tdata[42:33];
      spawn_y <= s_tdata[52:43];
      spawn_z <= s_tdata[62:53];
    end
    if (cmd.latch) begin
      res_joined <= 1'b0;
      res_x <= '0;
      res_y <= '0;
      res_z <= '0;
    end else if (cmd.append) begin
      res_joined <= 1'b1;
      res_x <= wx;
      res_y <= wy;
      res_z <= wz;
    end
    if (cmd.move) begin
      idx <= '0;
    end else if (rd_en) begin
      idx <= idx + cnt_t'(1);
    end
    if (cmd.move) hit <= 1'b0;
    else if (rd_valid && near1(wx, rd_data[COORD_W-1:0]) &&
             near1(wy, rd_data[2*COORD_W-1:COORD_W]) &&
             near1(wz, rd_data[3*COORD_W-1:2*COORD_W]))
      hit <= 1'b1;
    if (cmd.load_out) begin
      m_tdata <= {{(OUT_DATA_W-2-CNT_W-6*COORD_W){1'b0}}, done, size,
                  wz, wy, wx, res_z, res_y, res_x, res_joined};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wx       <= '0;
      wy       <= '0;
      wz       <= '0;
      size     <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      if (cmd.start) begin
        size <= cnt_t'(1);
        wx <= spawn_x;
        wy <= spawn_y;
        wz <= spawn_z;
      end else if (cmd.move) begin
        if (out_of_lattice) begin
          wx <= exit_x;
          wy <= exit_y;
          wz <= exit_z;
        end else begin
          wx <= nx[COORD_W-1:0];
          wy <= ny[COORD_W-1:0];
          wz <= nz[COORD_W-1:0];
        end
      end else if (cmd.append) begin
        size <= size + cnt_t'(1);
        wx <= spawn_x;
        wy <= spawn_y;
        wz <= spawn_z;
      end
    end
  end

  always_comb begin
    stat.is_start  = (op_q == OP_START);
    stat.is_done   = done;
    stat.scan_busy = (idx < size) || rd_valid;
    stat.hit       = hit;
  end

endmodule

`default_nettype wire

// File: rtl/dla_lattice_aggregation_step.sv
// Top level of the 3D lattice aggregation step: config registers, sequencer, datapath.
// Depends on dla_pkg, dla_ctrl and dla_dpath.
`default_nettype none

// One item in, one result out. A start item (tuser high) seeds the cluster at
// the lattice centre and places the walker at the spawn coordinates; a walk
// item moves the walker one cell, respawns it at the exit coordinates if it
// left the lattice, then compares it against every stored particle and, on
// contact, appends it and respawns it at the spawn coordinates. Once the
// cluster reaches target_size (or the 4096-entry store is full) walk items
// only report the unchanged state. A walk item reads the cluster store one
// particle per cycle, so its time from transfer in to result grows with the
// current cluster size; start items and walks after completion skip the
// scan. The block is ready for the next transfer in the cycle after the
// result is loaded. One item is in work at a time; the next transfer in is
// taken while a result still waits in the output register. The store needs
// no clearing after reset: only entries below the cluster size are read.
// Config writes are taken at any time but must only be issued while the
// block is idle.
module dla_lattice_aggregation_step (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config write port
  input  wire logic                          cfg_we,
  input  wire logic [dla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dla_pkg::CFG_W-1:0]     cfg_wdata,
  // item in
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [2:0] direction, [12:3] exit_x, [22:13] exit_y, [32:23] exit_z,
  // [42:33] spawn_x, [52:43] spawn_y, [62:53] spawn_z, [63] zero
  input  wire logic [dla_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic                          s_tuser,   // [0] op
  // result out
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [0] joined, [10:1] joined_x, [20:11] joined_y, [30:21] joined_z,
  // [40:31] walker_x, [50:41] walker_y, [60:51] walker_z,
  // [73:61] cluster_count, [74] done_res, [79:75] zero
  output logic [dla_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import dla_pkg::*;

  ext_t  lat_w, lat_h, lat_d;
  cnt_t  target;
  cmd_t  cmd;
  stat_t stat;

  // config registers, stored raw; the extents are clamped on use
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_w  <= RST_EXTENT;
      lat_h  <= RST_EXTENT;
      lat_d  <= RST_EXTENT;
      target <= RST_TARGET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  lat_w  <= cfg_wdata[EXT_W-1:0];
        CFG_HEIGHT: lat_h  <= cfg_wdata[EXT_W-1:0];
        CFG_DEPTH:  lat_d  <= cfg_wdata[EXT_W-1:0];
        CFG_TARGET: target <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  dla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dla_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tuser (s_tuser),
    .s_tdata (s_tdata),
    .ext_w   (clamp_extent(lat_w)),
    .ext_h   (clamp_extent(lat_h)),
    .ext_d   (clamp_extent(lat_d)),
    .target  (target),
    .stat    (stat),
    .m_tdata (m_tdata)
  );

`ifndef SYNTHESIS
  // the reported cluster never outgrows the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_CNT_LSB +: CNT_W] <= CNT_MAX))
    else $error("cluster count beyond store depth");

  // a join needs the seed already present
  a_join_after_seed: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[OUT_JOINED_LSB]) |-> (m_tdata[OUT_CNT_LSB +: CNT_W] >= cnt_t'(2)))
    else $error("join reported with no seed in cluster");

  // a new result only appears after the sequencer was busy
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result raised while idle");
`endif

endmodule

`default_nettype wire
